FILE: src/wfir_pkg.sv
// Shared types, constants and the weighted coefficient table for the windowed FIR.
// No dependencies; every other file of the block but wfir_ram imports this package.
`default_nettype none

package wfir_pkg;

  // Default configuration
  localparam int TAPS_DEF        = 51;
  localparam int SAMPLE_BITS_DEF = 12;

  // Coefficient table geometry and format (signed Q1.16)
  localparam int COEF_COUNT = 51;
  localparam int COEF_W     = 17;
  localparam int TAP_IDX_W  = 7;    // wide enough for the largest tap count

  // Result word format
  localparam int OUT_W   = 16;
  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

  // Hamming-weighted low-pass coefficients, tap 0 first
  localparam logic signed [COEF_W-1:0] WCOEF [COEF_COUNT] = '{
    17'sd0,      17'sd0,     17'sd0,     17'sd0,     17'sd0,
    17'sd0,     -17'sd52,    17'sd63,   -17'sd75,    17'sd0,
    17'sd0,     -17'sd116,   17'sd131,  -17'sd146,   17'sd160,
    -17'sd175,   17'sd377,  -17'sd201,   17'sd213,  -17'sd224,
    17'sd701,   -17'sd2173,  17'sd4707, -17'sd7821,  17'sd10203,
    17'sd54528,  17'sd10203, -17'sd7821, 17'sd4707, -17'sd2173,
    17'sd701,   -17'sd224,   17'sd213,  -17'sd201,   17'sd377,
    -17'sd175,   17'sd160,  -17'sd146,   17'sd131,  -17'sd116,
    17'sd0,      17'sd0,    -17'sd75,    17'sd63,   -17'sd52,
    17'sd0,      17'sd0,     17'sd0,     17'sd0,     17'sd0,
    17'sd0
  };

  // Coefficient for a tap; taps past the table have weight zero
  function automatic logic signed [COEF_W-1:0] wcoef(input logic [TAP_IDX_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (k < TAP_IDX_W'(COEF_COUNT)) begin
      c = WCOEF[k[5:0]];
    end
    return c;
  endfunction

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } wfir_state_t;

  // Sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clr;      // start a new sum
    logic tap_vld;  // a tap sample and coefficient are presented
  } mac_ctrl_t;

  // Multiply-accumulate unit back to sequencer
  typedef struct packed {
    logic busy;     // a product is still on its way into the sum
  } mac_sts_t;

endpackage

`default_nettype wire

FILE: src/wfir_in_if.sv
// Sample channel: valid/ready handshake carrying one ADC sample word.
// Depends on wfir_pkg for the default sample width.
`default_nettype none

interface wfir_in_if
  import wfir_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

FILE: src/wfir_out_if.sv
// Result channel: valid/ready handshake carrying one filtered output word.
// Depends on wfir_pkg for the output width.
`default_nettype none

interface wfir_out_if
  import wfir_pkg::*;
();

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);

endinterface

`default_nettype wire

FILE: src/wfir_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module wfir_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 51,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/wfir_mac.sv
// Shared multiply-accumulate unit: one tap product per cycle while tap_vld is set, into an exact sum,
// then divide by 65536 toward zero and saturate. Depends on wfir_pkg.
`default_nettype none

module wfir_mac
  import wfir_pkg::*;
#(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mac_ctrl_t               ctrl,
  input  wire logic [SAMPLE_BITS-1:0]  tap_data,
  input  wire logic signed [COEF_W-1:0] coef,
  output mac_sts_t                     sts,
  output logic signed [OUT_W-1:0]      result
);

  localparam int TAP_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PROD_W  = SAMPLE_BITS + 1 + COEF_W;
  localparam int ACC_RAW = PROD_W + TAP_W + 1;
  localparam int ACC_W   = (ACC_RAW > 33) ? ACC_RAW : 33;
  localparam int Q_W     = ACC_W - 16;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(OUT_MAX);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(OUT_MIN);

  logic signed [SAMPLE_BITS:0] samp_s;
  logic signed [PROD_W-1:0]    prod_r;
  logic                        prod_v_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic signed [Q_W-1:0]       quo;
  logic signed [Q_W-1:0]       quo_adj;

  assign samp_s = $signed({1'b0, tap_data});

  // Product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctrl.tap_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= samp_s * coef;
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign sts.busy = prod_v_r;

  // Divide by 65536 toward zero, then saturate
  always_comb begin
    quo     = acc_r[ACC_W-1:16];
    quo_adj = quo;
    if (acc_r[ACC_W-1] && (|acc_r[15:0])) begin
      quo_adj = quo + Q_W'(1);
    end
    if (quo_adj > Q_MAX) begin
      result = OUT_W'(OUT_MAX);
    end else if (quo_adj < Q_MIN) begin
      result = OUT_W'(OUT_MIN);
    end else begin
      result = quo_adj[OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/windowed_fir_filter_51tap.sv
// 51-tap Hamming-windowed low-pass FIR. Each accepted sample word is written into a
// circular delay line (newest at tap 0) and one filtered word is returned: the sum of
// sample times Q1.16 weighted coefficient over all taps, divided by 65536 toward zero
// and saturated to signed 16 bits. One multiplier walks the taps one per cycle: after
// the accept cycle come one delay-line read per tap and then the registered read,
// product and sum stages, and the result is loaded into the output register once that
// register is free. The input is ready again once the result has been loaded into the output
// register; a result waiting there does not block the next sample. The delay line
// reads as zero after reset through per-entry valid bits, with no clearing pass.
// Depends on wfir_pkg, wfir_in_if, wfir_out_if, wfir_ram and wfir_mac.
`default_nettype none

module windowed_fir_filter_51tap
  import wfir_pkg::*;
#(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wfir_in_if.sink    in_ch,
  wfir_out_if.source out_ch
);

  localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

  wfir_state_t              state_r, state_nxt;
  logic [TAP_W-1:0]         slot_r, slot_dec;
  logic [TAP_W-1:0]         rd_addr_r, rd_next;
  logic [TAP_W-1:0]         k_r, k1_r;
  logic [TAPS-1:0]          vld_r;
  logic                     vld_rd_r;
  logic                     s1_v_r;
  logic                     accept, issue, load_out;
  logic                     pipe_empty, out_free;
  logic [SAMPLE_BITS-1:0]   ram_rdata;
  logic [SAMPLE_BITS-1:0]   tap_data;
  logic signed [COEF_W-1:0] coef;
  mac_ctrl_t                mac_ctrl;
  mac_sts_t                 mac_sts;
  logic signed [OUT_W-1:0]  mac_result;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_data_r;

  // Handshake and pointer arithmetic
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_dec    = (slot_r == '0) ? LAST_TAP : slot_r - 1'b1;
  assign rd_next     = (rd_addr_r == LAST_TAP) ? '0 : rd_addr_r + 1'b1;
  assign pipe_empty  = !s1_v_r && !mac_sts.busy;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and strobes
  always_comb begin
    state_nxt = state_r;
    issue     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (k_r == LAST_TAP) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Newest slot and delay-line valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= LAST_TAP;
      vld_r  <= '0;
    end else if (accept) begin
      slot_r          <= slot_dec;
      vld_r[slot_dec] <= 1'b1;
    end
  end

  // Tap walk: read address and tap index
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addr_r <= slot_dec;
      k_r       <= '0;
    end else if (issue) begin
      rd_addr_r <= rd_next;
      k_r       <= k_r + 1'b1;
    end
  end

  // Align tap index and valid bit with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    k1_r     <= k_r;
    vld_rd_r <= vld_r[rd_addr_r];
  end

  wfir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAPS)
  ) u_dline (
    .clk   (clk),
    .we    (accept),
    .waddr (slot_dec),
    .wdata (in_ch.sample),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // Never-written entries read as zero
  assign tap_data     = vld_rd_r ? ram_rdata : '0;
  assign coef         = wcoef(TAP_IDX_W'(k1_r));
  assign mac_ctrl.clr     = accept;
  assign mac_ctrl.tap_vld = s1_v_r;

  wfir_mac #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (mac_ctrl),
    .tap_data (tap_data),
    .coef     (coef),
    .sts      (mac_sts),
    .result   (mac_result)
  );

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= mac_result;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = out_data_r;

endmodule

`default_nettype wire

FILE: tb/sv/windowed_fir_filter_51tap_test.sv
// Self-checking test of the 51-tap Hamming-windowed FIR: random and directed sample
// words in, every filtered word checked against a tap-by-tap model of the filter.
// Depends on wfir_pkg, wfir_in_if, wfir_out_if and windowed_fir_filter_51tap.
`timescale 1ns / 1ps

module windowed_fir_filter_51tap_test;
  import wfir_pkg::*;

  localparam int TAP_COUNT  = 51;
  localparam int SMP_W      = SAMPLE_BITS_DEF;
  localparam int SMP_MAX    = (1 << SMP_W) - 1;
  localparam int WORD_TOTAL = 700;
  localparam int HOLD_LEN   = 400;
  localparam int SETTLE_CYC = 60;

  // Weighted Q1.16 coefficients, tap 0 (newest sample) first
  localparam int FIR_COEF [TAP_COUNT] = '{
        0,     0,     0,     0,     0,     0,   -52,    63,   -75,     0,
        0,  -116,   131,  -146,   160,  -175,   377,  -201,   213,  -224,
      701, -2173,  4707, -7821, 10203, 54528, 10203, -7821,  4707, -2173,
      701,  -224,   213,  -201,   377,  -175,   160,  -146,   131,  -116,
        0,     0,   -75,    63,   -52,     0,     0,     0,     0,     0,
        0
  };

  typedef enum int {
    SEG_UNIFORM,
    SEG_PEAK_POS,
    SEG_PEAK_NEG,
    SEG_IMPULSE,
    SEG_LEVEL,
    SEG_RAILS
  } seg_kind_t;

  typedef struct {
    logic [SMP_W-1:0] value;
    bit               drain;   // wait for all results before offering this word
  } sample_word_t;

  logic clk = 1'b0;
  logic rst_n;

  wfir_in_if  in_ch ();
  wfir_out_if out_ch ();

  windowed_fir_filter_51tap i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sample_word_t            sample_q [$];
  logic signed [OUT_W-1:0] filtered_q [$];

  // Model state: delay line and index of the newest entry
  logic [SMP_W-1:0] tap_hist [TAP_COUNT];
  int               newest_slot;

  int error_cnt;
  int accepted_cnt;
  int hold_cnt;
  int hold_mark;
  int burst_left;
  int gap_left;
  int rx_mode;
  int rx_mode_left;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    error_cnt++;
    $display("%0t ns: %s: expected %0d, got %0d", $realtime, what, exp_val, got_val);
  endtask

  // Push a word into the delay line and return the filtered word it produces
  function automatic logic signed [OUT_W-1:0] filter_sample(input logic [SMP_W-1:0] s);
    longint acc;
    longint quo;
    int     slot;
    newest_slot = (newest_slot == 0) ? TAP_COUNT - 1 : newest_slot - 1;
    tap_hist[newest_slot] = s;
    acc  = 0;
    slot = newest_slot;
    for (int k = 0; k < TAP_COUNT; k++) begin
      acc += longint'(tap_hist[slot]) * longint'(FIR_COEF[k]);
      slot = (slot == TAP_COUNT - 1) ? 0 : slot + 1;
    end
    // Signed division truncates toward zero
    quo = acc / 65536;
    if (quo > OUT_MAX) quo = OUT_MAX;
    if (quo < OUT_MIN) quo = OUT_MIN;
    return quo[OUT_W-1:0];
  endfunction

  task automatic add_word(input int value, input bit drain = 1'b0);
    sample_word_t w;
    w.value = value[SMP_W-1:0];
    w.drain = drain;
    sample_q.push_back(w);
  endtask

  // Sender: predict on acceptance, offer words in bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.sample <= '0;
      accepted_cnt <= 0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        filtered_q.push_back(filter_sample(in_ch.sample));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 && hold_cnt == 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (sample_q.size() != 0 && !(sample_q[0].drain && filtered_q.size() != 0)) begin
          in_ch.valid  <= 1'b1;
          in_ch.sample <= sample_q[0].value;
          void'(sample_q.pop_front());
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started twice during the run
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt  <= 0;
      hold_mark <= -1;
    end else if (hold_cnt == 0 && (accepted_cnt == 150 || accepted_cnt == 480)
                 && hold_mark != accepted_cnt) begin
      hold_cnt  <= HOLD_LEN;
      hold_mark <= accepted_cnt;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Receiver: ready pattern switches between several stall modes
  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode      = 0;
      rx_mode_left = 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(32, 300);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: begin
          rdy = 1'b1;
        end
        1: begin
          rdy = ($urandom_range(0, 1) != 0);
        end
        2: begin
          rdy = ($urandom_range(0, 3) != 0);
        end
        default: begin
          rdy = ($urandom_range(0, 3) == 0);
        end
      endcase
      out_ch.ready <= rdy && (hold_cnt == 0);
    end
  end

  // Check each accepted result word against the oldest prediction
  always @(posedge clk) begin
    logic signed [OUT_W-1:0] exp_word;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected filtered word", 0, out_ch.filtered);
      end else begin
        exp_word = filtered_q.pop_front();
        if (out_ch.filtered !== exp_word) begin
          report_mismatch("filtered mismatch", exp_word, out_ch.filtered);
        end
      end
    end
  end

  initial begin
    int        n;
    int        len;
    int        level;
    seg_kind_t kind;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    error_cnt    = 0;
    newest_slot  = TAP_COUNT - 1;
    foreach (tap_hist[i]) tap_hist[i] = '0;

    // Directed: rails, single-bit and alternating patterns, mid-scale edges
    add_word(SMP_MAX);
    add_word(SMP_MAX);
    add_word(0);
    add_word(0);
    add_word(SMP_MAX);
    add_word(0);
    add_word(1);
    add_word(12'h800);
    add_word(12'h7FF);
    add_word(12'hAAA);
    add_word(12'h555);
    add_word(12'hFFF);
    add_word(12'h001);
    for (int b = 0; b < SMP_W; b += 2) add_word(1 << b);
    add_word(0);

    // Random: whole-window sequences with random content, and noise
    n = sample_q.size();
    while (n < WORD_TOTAL) begin
      kind = seg_kind_t'($urandom_range(0, 5));
      len  = TAP_COUNT;
      for (int j = 0; j < len; j++) begin
        case (kind)
          SEG_PEAK_POS: begin
            if (FIR_COEF[TAP_COUNT-1-j] > 0) level = SMP_MAX;
            else if (FIR_COEF[TAP_COUNT-1-j] < 0) level = 0;
            else level = $urandom_range(0, SMP_MAX);
          end
          SEG_PEAK_NEG: begin
            if (FIR_COEF[TAP_COUNT-1-j] < 0) level = SMP_MAX;
            else if (FIR_COEF[TAP_COUNT-1-j] > 0) level = 0;
            else level = $urandom_range(0, SMP_MAX);
          end
          SEG_IMPULSE: begin
            level = (j == 0) ? $urandom_range(1, SMP_MAX) : 0;
          end
          SEG_LEVEL: begin
            if (j == 0) level = $urandom_range(0, SMP_MAX);
          end
          SEG_RAILS: begin
            level = $urandom_range(0, 1) ? SMP_MAX : 0;
          end
          default: begin
            level = $urandom_range(0, SMP_MAX);
          end
        endcase
        // Drain the block early in the random part and once midway
        add_word(level, (n == 25 || n == 400) ? 1'b1 : 1'b0);
        n++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all words to be accepted and all results returned
    while (sample_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (filtered_q.size() != 0) begin
      report_mismatch("words still expected", filtered_q.size(), 0);
    end
    if (error_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #12_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
